FILE: rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/rcfd_pkg.sv
package rcfd_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] wheel_pos;
    logic [1:0]         switch_one;
    logic [1:0]         switch_two;
    logic [1:0]         loss_action;
    logic               link_up;
  } out_item_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_IDLE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [2:0] REG_MIN    = 3'd0;
  localparam logic [2:0] REG_MID    = 3'd1;
  localparam logic [2:0] REG_MAX    = 3'd2;
  localparam logic [2:0] REG_DB     = 3'd3;
  localparam logic [2:0] REG_TMO    = 3'd4;
  localparam logic [2:0] REG_HOLD   = 3'd5;
  localparam logic [2:0] REG_HEADER = 3'd6;

  localparam logic [1:0] MODE_ONLINE = 2'd0;
  localparam logic [1:0] MODE_STOP   = 2'd1;
  localparam logic [1:0] MODE_CUTOFF = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ESTOP = 2'd1;
  localparam logic [1:0] ACT_CUT   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic ch_store;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic div_busy;
    logic last_ch;
    logic is_idle;
    logic is_tick;
    logic out_taken;
  } sts_t;

endpackage

FILE: rtl/rcfd_ctrl.sv
module rcfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rcfd_pkg::sts_t    sts,
  output logic              in_ready,
  output logic              out_valid,
  output rcfd_pkg::cmd_t    cmd
);

  rcfd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcfd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcfd_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.is_idle && sts.full) state_nxt = rcfd_pkg::ST_LOAD;
          else if (sts.is_tick) state_nxt = rcfd_pkg::ST_OUT;
        end
      end
      rcfd_pkg::ST_LOAD: state_nxt = rcfd_pkg::ST_DIV;
      rcfd_pkg::ST_DIV:  if (!sts.div_busy) state_nxt = rcfd_pkg::ST_NEXT;
      rcfd_pkg::ST_NEXT: state_nxt = sts.last_ch ? rcfd_pkg::ST_OUT : rcfd_pkg::ST_LOAD;
      rcfd_pkg::ST_OUT:  if (sts.out_taken) state_nxt = rcfd_pkg::ST_IDLE;
      default: state_nxt = rcfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      rcfd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      rcfd_pkg::ST_LOAD: cmd.div_start = 1'b1;
      rcfd_pkg::ST_NEXT: begin
        cmd.ch_store = 1'b1;
        cmd.finish = sts.last_ch;
      end
      rcfd_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/rcfd_datapath.sv
module rcfd_datapath #(
  parameter int FRAME_BYTES    = 18,
  parameter int BURST_CAPACITY = 64,
  parameter int FRACTION_BITS  = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcfd_pkg::in_item_t   in_data,
  input  rcfd_pkg::cmd_t       cmd,
  input  logic                 out_ready,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  output rcfd_pkg::sts_t       sts,
  output rcfd_pkg::out_item_t  out_data
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int BW = $clog2(BURST_CAPACITY + 1);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int NW = 11 + FRACTION_BITS + 1;
  localparam int QW = FRACTION_BITS + 2;

  logic [10:0] min_r, mid_r, max_r;
  logic [14:0] db_r;
  logic [15:0] tmo_r, hold_r;
  logic [7:0]  hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 11'd364; mid_r <= 11'd1024; max_r <= 11'd1684;
      db_r <= 15'd819; tmo_r <= 16'd100; hold_r <= 16'd500; hdr_r <= 8'd160;
    end else if (cfg_we) begin
      case (cfg_index)
        rcfd_pkg::REG_MIN:    min_r <= cfg_wdata[10:0];
        rcfd_pkg::REG_MID:    mid_r <= cfg_wdata[10:0];
        rcfd_pkg::REG_MAX:    max_r <= cfg_wdata[10:0];
        rcfd_pkg::REG_DB:     db_r <= cfg_wdata[14:0];
        rcfd_pkg::REG_TMO:    tmo_r <= cfg_wdata;
        rcfd_pkg::REG_HOLD:   hold_r <= cfg_wdata;
        rcfd_pkg::REG_HEADER: hdr_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0] store_r [FRAME_BYTES];
  logic [BW-1:0] burst_r;
  logic [CW-1:0] cap_r;
  logic capturing_r;
  logic [31:0] now_r, last_r, entry_r;
  logic [1:0] mode_r;

  logic is_byte, is_idle, is_tick, cap_now;
  assign is_byte = in_data.kind == rcfd_pkg::KIND_BYTE;
  assign is_idle = in_data.kind == rcfd_pkg::KIND_IDLE;
  assign is_tick = in_data.kind == rcfd_pkg::KIND_TICK;
  assign cap_now = capturing_r || (in_data.rx_byte == hdr_r);

  always_ff @(posedge clk) begin
    if (cmd.accept && is_byte && burst_r < BW'(BURST_CAPACITY) && cap_now
        && cap_r < CW'(FRAME_BYTES)) begin
      store_r[cap_r[AW-1:0]] <= in_data.rx_byte;
    end
  end

  logic [31:0] now_inc, since_frame, since_loss;
  logic up_tick;
  assign now_inc = now_r + 32'd1;
  assign since_frame = now_inc - last_r;
  assign since_loss = now_inc - entry_r;
  assign up_tick = since_frame < {16'd0, tmo_r};

  // channel sequencing
  logic [2:0] ch_r;
  logic [10:0] raw;
  logic [AW-1:0] lo_idx, hi_idx;
  assign lo_idx = AW'(2 * ch_r + 1);
  assign hi_idx = AW'(2 * ch_r + 2);
  assign raw = {store_r[hi_idx][2:0], store_r[lo_idx]};

  logic neg_r, sat_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [10:0] den_r;
  logic [NW-1:0] num_r;
  logic [5:0] bit_r;
  logic busy_r;

  logic [10:0] den_c, diff_c;
  logic neg_c, sat_c;
  always_comb begin
    neg_c = 1'b0; sat_c = 1'b0; den_c = 11'd1; diff_c = '0;
    if (raw <= min_r) begin
      sat_c = 1'b1; neg_c = 1'b1;
    end else if (raw >= max_r) begin
      sat_c = 1'b1;
    end else if (raw < mid_r) begin
      neg_c = 1'b1; den_c = mid_r - min_r; diff_c = mid_r - raw;
    end else begin
      den_c = max_r - mid_r; diff_c = raw - mid_r;
    end
  end

  logic [NW:0] trial;
  assign trial = {rem_r, num_r[NW-1]} - {{(NW-10){1'b0}}, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      bit_r <= 6'(NW);
      neg_r <= neg_c; sat_r <= sat_c; den_r <= den_c;
      num_r <= NW'({diff_c, {FRACTION_BITS{1'b0}}}) + NW'(den_c >> 1);
      rem_r <= '0; quo_r <= '0;
    end else if (busy_r) begin
      if (!trial[NW]) begin
        rem_r <= trial[NW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[NW-2:0], num_r[NW-1]};
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
      num_r <= {num_r[NW-2:0], 1'b0};
      bit_r <= bit_r - 6'd1;
      if (bit_r == 6'd1) busy_r <= 1'b0;
    end
  end

  logic [QW-1:0] mag;
  logic signed [16:0] sval;
  logic signed [15:0] res;
  assign mag = sat_r ? QW'(1 << FRACTION_BITS) : quo_r[QW-1:0];
  always_comb begin
    sval = neg_r ? -$signed({1'b0, 16'(mag)}) : $signed({1'b0, 16'(mag)});
    if ({{(17-QW){1'b0}}, mag} < {2'b0, db_r}) res = '0;
    else if (sval > 17'sd32767) res = 16'sd32767;
    else res = sval[15:0];
  end

  logic signed [15:0] sticks_r [5];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (cmd.accept) begin
      ch_r <= '0;
    end else if (cmd.ch_store) begin
      sticks_r[ch_r] <= res;
      ch_r <= ch_r + 3'd1;
    end
  end

  function automatic logic [1:0] dec_sw(input logic [6:0] code);
    if (code == 7'd0) return 2'd0;
    if (code == 7'd1) return 2'd1;
    return 2'd2;
  endfunction

  rcfd_pkg::out_item_t tick_res, frame_res;

  always_comb begin
    tick_res = '0;
    tick_res.result_kind = 1'b1;
    tick_res.link_up = up_tick;
    tick_res.loss_action = rcfd_pkg::ACT_NONE;
    if (!up_tick) begin
      if (mode_r == rcfd_pkg::MODE_ONLINE) begin
        tick_res.loss_action = rcfd_pkg::ACT_ESTOP;
      end else if (mode_r == rcfd_pkg::MODE_STOP && since_loss >= {16'd0, hold_r}) begin
        tick_res.loss_action = rcfd_pkg::ACT_CUT;
      end
    end
  end

  always_comb begin
    frame_res = '0;
    frame_res.result_kind = 1'b0;
    frame_res.left_x = sticks_r[0];
    frame_res.left_y = sticks_r[1];
    frame_res.right_x = sticks_r[2];
    frame_res.right_y = sticks_r[3];
    frame_res.wheel_pos = res;
    frame_res.switch_one = dec_sw({3'b0, store_r[12][7:6], store_r[11][1:0]});
    frame_res.switch_two = dec_sw({store_r[13][7:5], 4'b0} | {1'b0, store_r[12][5:0]});
    frame_res.loss_action = rcfd_pkg::ACT_NONE;
    frame_res.link_up = tmo_r != 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r <= '0; cap_r <= '0; capturing_r <= 1'b0;
      now_r <= '0; last_r <= '0; entry_r <= '0; mode_r <= rcfd_pkg::MODE_ONLINE;
    end else begin
      if (cmd.accept && is_byte && burst_r < BW'(BURST_CAPACITY)) begin
        burst_r <= burst_r + BW'(1);
        capturing_r <= cap_now;
        if (cap_now && cap_r < CW'(FRAME_BYTES)) cap_r <= cap_r + CW'(1);
      end
      if (cmd.accept && is_idle) begin
        burst_r <= '0; cap_r <= '0; capturing_r <= 1'b0;
      end
      if (cmd.accept && is_tick) begin
        now_r <= now_inc;
        out_data <= tick_res;
        if (!up_tick) begin
          if (mode_r == rcfd_pkg::MODE_ONLINE) begin
            mode_r <= rcfd_pkg::MODE_STOP;
            entry_r <= now_inc;
          end else if (mode_r == rcfd_pkg::MODE_STOP && since_loss >= {16'd0, hold_r}) begin
            mode_r <= rcfd_pkg::MODE_CUTOFF;
          end
        end
      end
      if (cmd.finish) begin
        last_r <= now_r;
        if (mode_r != rcfd_pkg::MODE_ONLINE) begin
          mode_r <= rcfd_pkg::MODE_ONLINE;
          entry_r <= '0;
        end
        out_data <= frame_res;
      end
    end
  end

  assign sts.full = capturing_r && cap_r >= CW'(FRAME_BYTES);
  assign sts.div_busy = busy_r;
  assign sts.last_ch = ch_r == 3'd4;
  assign sts.is_idle = is_idle;
  assign sts.is_tick = is_tick;
  assign sts.out_taken = out_ready;

endmodule

FILE: rtl/rc_frame_decoder_with_link_loss.sv
// Remote-control frame decoder with link-loss supervision.
// Input channel (in_valid/in_ready/in_data): kind 0 carries a received byte,
// kind 1 marks end of burst, kind 2 is a one millisecond tick.
// Output channel (out_valid/out_ready/out_data): a decoded frame after an
// idle event with a full capture, or a link-loss report after every tick.
// Bytes are taken while idle. A tick result appears in the cycle after its accept.
// A frame decode runs five stick channels through one restoring divider of
// FRACTION_BITS+12 steps per channel, one channel after another.
// Only one transaction is in flight; in_ready is low until the result is
// taken, so a stalled receiver holds the block with its output steady.
// Synchronous reset restores register defaults, clears the burst and
// capture counters, time counters and loss mode (online).
// Configuration writes are accepted any cycle via cfg_we/cfg_index/cfg_wdata.
module rc_frame_decoder_with_link_loss #(
  parameter int FRAME_BYTES    = 18,
  parameter int BURST_CAPACITY = 64,
  parameter int FRACTION_BITS  = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcfd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcfd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  rcfd_pkg::cmd_t cmd;
  rcfd_pkg::sts_t sts;

  rcfd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .sts, .in_ready, .out_valid, .cmd
  );

  rcfd_datapath #(
    .FRAME_BYTES(FRAME_BYTES), .BURST_CAPACITY(BURST_CAPACITY),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk, .rst_n, .in_data, .cmd, .out_ready, .cfg_we, .cfg_index, .cfg_wdata,
    .sts, .out_data
  );

`include "assert_macros.svh"

  `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "ready while result pending")
  `ASSERT_NEXT(a_tick_result, clk, rst_n, in_valid && in_ready && in_data.kind == rcfd_pkg::KIND_TICK, out_valid && out_data.result_kind, "tick gave no result")
  `ASSERT_IMPL(a_act_range, clk, rst_n, out_valid, out_data.loss_action != 2'd3, "bad loss action")

endmodule
